FILE: rtl/button_press_duration_decoder_macros.svh
// Assertion macros used by the button press duration decoder checker.
`ifndef BUTTON_PRESS_DURATION_DECODER_MACROS_SVH
`define BUTTON_PRESS_DURATION_DECODER_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define BPDD_ASSERT(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequence must hold at the clock edge after the antecedent.
`define BPDD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bpdd_pkg.sv
// Types and constants of the button press duration decoder.
package bpdd_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned THRESH_W   = 16;
  localparam int unsigned STEP_W     = 8;
  localparam int unsigned NOW_W      = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LONG_HOLD   = 3'd0,
    CFG_SWITCH_HOLD = 3'd1,
    CFG_MIN_PRESS   = 3'd2,
    CFG_TEMP_STEP   = 3'd3,
    CFG_HUM_STEP    = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_TEST   = 2'd1,
    EV_TARGET = 2'd2,
    EV_STEP   = 2'd3
  } event_e;

  localparam logic [THRESH_W-1:0] LONG_HOLD_RST   = 16'd10000;
  localparam logic [THRESH_W-1:0] SWITCH_HOLD_RST = 16'd1000;
  localparam logic [THRESH_W-1:0] MIN_PRESS_RST   = 16'd100;
  localparam logic [STEP_W-1:0]   TEMP_STEP_RST   = 8'd1;
  localparam logic [STEP_W-1:0]   HUM_STEP_RST    = 8'd5;
  localparam int unsigned         TEMP_RST        = 25;
  localparam int unsigned         HUM_RST         = 30;

endpackage

FILE: rtl/bpdd_stream_if.sv
// Valid/ready channel interfaces for button scans and decoded results.
interface bpdd_in_if;
  logic                         valid;
  logic                         ready;
  logic                         sample_level;
  logic                         confirm_level;
  logic [bpdd_pkg::NOW_W-1:0]   now_ms;

  modport source (output valid, sample_level, confirm_level, now_ms, input ready);
  modport sink   (input valid, sample_level, confirm_level, now_ms, output ready);
endinterface

interface bpdd_out_if #(
  parameter int unsigned VALUE_WIDTH = 10
);
  logic                   valid;
  logic                   ready;
  logic                   test_mode;
  logic                   edit_temperature;
  logic [VALUE_WIDTH-1:0] sim_temperature;
  logic [VALUE_WIDTH-1:0] sim_humidity;
  logic [1:0]             event_res;

  modport source (output valid, test_mode, edit_temperature, sim_temperature, sim_humidity,
                  event_res, input ready);
  modport sink   (input valid, test_mode, edit_temperature, sim_temperature, sim_humidity,
                  event_res, output ready);
endinterface

FILE: rtl/button_press_duration_decoder.sv
// Top level of the button press duration decoder.
// A scan is held in the scan register, and its result is registered in the result register.
// Throughput: one scan per cycle unless the output stalls; the scan and result registers each
// hold one transaction, so a new scan is taken while a finished result waits to be taken.
// Reset: asynchronous, active low; clears both valid bits, loads the default thresholds
// and steps, and returns the button tracking and simulated values to their start state.
module button_press_duration_decoder #(
  parameter int unsigned VALUE_WIDTH = 10,
  parameter int unsigned TIME_WIDTH  = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bpdd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bpdd_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  bpdd_in_if.sink                          in_i,
  bpdd_out_if.source                       out_o
);

  localparam int unsigned SUM_W = ((VALUE_WIDTH > bpdd_pkg::STEP_W) ?
                                   VALUE_WIDTH : bpdd_pkg::STEP_W) + 1;
  localparam logic [VALUE_WIDTH-1:0] VALUE_MAX = '1;

  logic [bpdd_pkg::THRESH_W-1:0] long_hold_q, switch_hold_q, min_press_q;
  logic [bpdd_pkg::STEP_W-1:0]   temp_step_q, hum_step_q;

  logic                   s1_valid_q;
  logic                   s1_sample_q;
  logic                   s1_confirm_q;
  logic [TIME_WIDTH-1:0]  s1_now_q;

  logic                   last_level_q, last_level_d;
  logic                   pressing_q, pressing_d;
  logic                   long_q, long_d;
  logic [TIME_WIDTH-1:0]  press_start_q, press_start_d;
  logic                   test_q, test_d;
  logic                   edit_q, edit_d;
  logic [VALUE_WIDTH-1:0] temp_q, temp_d;
  logic [VALUE_WIDTH-1:0] hum_q, hum_d;
  bpdd_pkg::event_e       event_d;

  logic                   out_valid_q;
  logic                   out_test_q;
  logic                   out_edit_q;
  logic [VALUE_WIDTH-1:0] out_temp_q;
  logic [VALUE_WIDTH-1:0] out_hum_q;
  logic [1:0]             out_event_q;

  logic                   out_free;
  logic                   s1_fire;
  logic                   level;
  logic                   fall;
  logic                   rise;
  logic                   long_eff;
  logic [TIME_WIDTH-1:0]  hold;
  logic [SUM_W-1:0]       temp_sum;
  logic [SUM_W-1:0]       hum_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_hold_q   <= bpdd_pkg::LONG_HOLD_RST;
      switch_hold_q <= bpdd_pkg::SWITCH_HOLD_RST;
      min_press_q   <= bpdd_pkg::MIN_PRESS_RST;
      temp_step_q   <= bpdd_pkg::TEMP_STEP_RST;
      hum_step_q    <= bpdd_pkg::HUM_STEP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bpdd_pkg::CFG_LONG_HOLD:   long_hold_q   <= cfg_data_i;
        bpdd_pkg::CFG_SWITCH_HOLD: switch_hold_q <= cfg_data_i;
        bpdd_pkg::CFG_MIN_PRESS:   min_press_q   <= cfg_data_i;
        bpdd_pkg::CFG_TEMP_STEP:   temp_step_q   <= cfg_data_i[bpdd_pkg::STEP_W-1:0];
        bpdd_pkg::CFG_HUM_STEP:    hum_step_q    <= cfg_data_i[bpdd_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_free   = !out_valid_q || out_o.ready;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_sample_q  <= in_i.sample_level;
      s1_confirm_q <= in_i.confirm_level;
      s1_now_q     <= in_i.now_ms[TIME_WIDTH-1:0];
    end
  end

  // The confirming re-read only matters when the first sample disagrees with the last level.
  always_comb begin
    level         = (s1_sample_q != last_level_q) ? s1_confirm_q : s1_sample_q;
    fall          = !level && last_level_q;
    rise          = level && !last_level_q;
    press_start_d = fall ? s1_now_q : press_start_q;
    pressing_d    = fall || pressing_q;
    long_eff      = fall ? 1'b0 : long_q;
    long_d        = long_eff;
    hold          = s1_now_q - press_start_d;
    test_d        = test_q;
    edit_d        = edit_q;
    temp_d        = temp_q;
    hum_d         = hum_q;
    event_d       = bpdd_pkg::EV_NONE;
    last_level_d  = level;
    temp_sum      = SUM_W'(temp_q) + SUM_W'(temp_step_q);
    hum_sum       = SUM_W'(hum_q) + SUM_W'(hum_step_q);

    if (!level && pressing_d && !long_eff && (hold >= TIME_WIDTH'(long_hold_q))) begin
      test_d  = !test_q;
      long_d  = 1'b1;
      event_d = bpdd_pkg::EV_TEST;
    end

    if (rise) begin
      if (test_q && !long_q) begin
        if (hold >= TIME_WIDTH'(switch_hold_q)) begin
          edit_d  = !edit_q;
          event_d = bpdd_pkg::EV_TARGET;
        end else if (hold >= TIME_WIDTH'(min_press_q)) begin
          if (edit_q) begin
            temp_d = (temp_sum > SUM_W'(VALUE_MAX)) ? VALUE_MAX : temp_sum[VALUE_WIDTH-1:0];
          end else begin
            hum_d = (hum_sum > SUM_W'(VALUE_MAX)) ? VALUE_MAX : hum_sum[VALUE_WIDTH-1:0];
          end
          event_d = bpdd_pkg::EV_STEP;
        end
      end
      pressing_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_level_q  <= 1'b1;
      pressing_q    <= 1'b0;
      long_q        <= 1'b0;
      press_start_q <= '0;
      test_q        <= 1'b0;
      edit_q        <= 1'b1;
      temp_q        <= VALUE_WIDTH'(bpdd_pkg::TEMP_RST);
      hum_q         <= VALUE_WIDTH'(bpdd_pkg::HUM_RST);
    end else if (s1_fire) begin
      last_level_q  <= last_level_d;
      pressing_q    <= pressing_d;
      long_q        <= long_d;
      press_start_q <= press_start_d;
      test_q        <= test_d;
      edit_q        <= edit_d;
      temp_q        <= temp_d;
      hum_q         <= hum_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_test_q  <= test_d;
      out_edit_q  <= edit_d;
      out_temp_q  <= temp_d;
      out_hum_q   <= hum_d;
      out_event_q <= event_d;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.test_mode        = out_test_q;
  assign out_o.edit_temperature = out_edit_q;
  assign out_o.sim_temperature  = out_temp_q;
  assign out_o.sim_humidity     = out_hum_q;
  assign out_o.event_res        = out_event_q;

endmodule

FILE: rtl/bpdd_checker.sv
// Port-level checker for the button press duration decoder, with its bind statement.
`include "button_press_duration_decoder_macros.svh"

module bpdd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       test_mode_i,
  input logic       edit_temperature_i,
  input logic [1:0] event_res_i
);

  logic out_acc;
  logic prev_test_q;
  logic prev_edit_q;

  assign out_acc = out_valid_i && out_ready_i;

  // Flags of the last delivered transaction, starting from their reset values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_test_q <= 1'b0;
      prev_edit_q <= 1'b1;
    end else if (out_acc) begin
      prev_test_q <= test_mode_i;
      prev_edit_q <= edit_temperature_i;
    end
  end

  `BPDD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(event_res_i), "stalled result changed")
  `BPDD_ASSERT(a_step_in_test, clk_i, rst_ni, !(out_acc && (event_res_i == bpdd_pkg::EV_STEP || event_res_i == bpdd_pkg::EV_TARGET)) || test_mode_i, "step or target toggle outside test mode")
  `BPDD_ASSERT(a_test_toggle, clk_i, rst_ni, !(out_acc && event_res_i != bpdd_pkg::EV_TEST) || (test_mode_i == prev_test_q), "test mode changed without its event")
  `BPDD_ASSERT(a_edit_toggle, clk_i, rst_ni, !(out_acc && event_res_i != bpdd_pkg::EV_TARGET) || (edit_temperature_i == prev_edit_q), "edit target changed without its event")

endmodule

bind button_press_duration_decoder bpdd_checker u_bpdd_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .test_mode_i        (out_o.test_mode),
  .edit_temperature_i (out_o.edit_temperature),
  .event_res_i        (out_o.event_res)
);
